>>> rtl/i2cmls_pkg.sv
// Package: shared types and constants of the I2C master line sequencer.
`default_nettype none

package i2cmls_pkg;

   localparam int unsigned CFG_W         = 10;
   localparam int unsigned COUNTER_W     = 10;
   localparam int unsigned BITS_PER_BYTE = 8;

   localparam logic [2:0] FUNC_NONE  = 3'd0;
   localparam logic [2:0] FUNC_START = 3'd1;
   localparam logic [2:0] FUNC_WRITE = 3'd2;
   localparam logic [2:0] FUNC_READ  = 3'd3;
   localparam logic [2:0] FUNC_STOP  = 3'd4;

   localparam logic CSR_PAUSE_TICKS   = 1'b0;
   localparam logic CSR_STRETCH_LIMIT = 1'b1;

   localparam logic [CFG_W-1:0] PAUSE_TICKS_RESET   = 10'd4;
   localparam logic [CFG_W-1:0] STRETCH_LIMIT_RESET = 10'd255;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic       scl_in;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
      logic       stretch_timeout;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/i2c_master_line_sequencer_unit.sv
// Top level: request register, line sequencer engine, result register and settings.
//
// Each request is one tick of an open-drain I2C master: a command field plus the
// sampled SCL and SDA levels. Each request yields exactly one result holding the
// line drive levels, busy and done flags, the last received byte, the last ACK
// seen and the clock stretch timeout flag.
// A request taken at one clock edge sits in the request register and is processed at
// an edge where the result register advances, which loads its result there. One
// request per cycle is sustained while results are taken, as the state update is a
// single pass between the registers. When the receiver stalls, the result register
// holds and the request register still takes one more request; further requests
// wait until a result is taken. The user must write the pause length and stretch
// limit through the settings port only while the block is idle; the block does not
// enforce this. Reset empties both registers, returns the engine to idle with both
// lines released, and restores the settings to 4 and 255.
`default_nettype none

module i2c_master_line_sequencer_unit #(
   parameter int unsigned COUNTER_BITS = i2cmls_pkg::COUNTER_W
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire i2cmls_pkg::req_type          req_data,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      i2cmls_pkg::rsp_type          rsp_data,
   input  wire logic                         csr_we,
   input  wire logic                         csr_index,
   input  wire logic [i2cmls_pkg::CFG_W-1:0] csr_wdata
);
   import i2cmls_pkg::*;

   logic             in_valid_ff;
   req_type          in_data_ff;
   logic             out_valid_ff;
   rsp_type          out_data_ff;
   rsp_type          step_rsp;
   logic [CFG_W-1:0] pause_ticks_ff;
   logic [CFG_W-1:0] stretch_limit_ff;
   logic             advance;
   logic             fire;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   i2cmls_engine #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .req          (in_data_ff),
      .pause_ticks  (pause_ticks_ff),
      .stretch_limit(stretch_limit_ff),
      .rsp          (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pause_ticks_ff   <= PAUSE_TICKS_RESET;
         stretch_limit_ff <= STRETCH_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAUSE_TICKS:   pause_ticks_ff   <= csr_wdata;
            CSR_STRETCH_LIMIT: stretch_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.done_res) |-> !out_data_ff.busy_res)
      else $error("done result still reports busy");

   a_request_moves: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> out_valid_ff)
      else $error("processed request produced no result");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while both registers are full");

endmodule

`default_nettype wire

>>> rtl/i2cmls_engine.sv
// Line sequencer state machine: advances one tick per request and forms its result.
`default_nettype none

module i2cmls_engine #(
   parameter int unsigned COUNTER_BITS = i2cmls_pkg::COUNTER_W
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire i2cmls_pkg::req_type            req,
   input  wire logic [i2cmls_pkg::CFG_W-1:0]   pause_ticks,
   input  wire logic [i2cmls_pkg::CFG_W-1:0]   stretch_limit,
   output      i2cmls_pkg::rsp_type            rsp
);
   import i2cmls_pkg::*;

   localparam int unsigned CMPW = ((COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W) + 1;

   typedef enum logic [4:0] {
      PH_IDLE,
      ST_P1, ST_W, ST_P2, ST_P3,
      WB_P1, WB_P2, WB_W, WA_P1, WA_P2, WA_W,
      RB_P0, RB_P1, RB_W, RB_P2, RA_P1, RA_W, RA_P2, RA_P3,
      SP_P1, SP_P2, SP_W, SP_P3
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [3:0]              bit_count_ff, bit_count_in;
   logic [7:0]              shift_ff, shift_in;
   logic [COUNTER_BITS-1:0] pause_ff, pause_in;
   logic [COUNTER_BITS-1:0] stretch_ff, stretch_in;
   logic                    scl_drive_ff, scl_drive_in;
   logic                    sda_drive_ff, sda_drive_in;
   logic                    ack_hold_ff, ack_hold_in;
   logic [7:0]              recv_ff, recv_in;
   logic                    ack_flag_ff, ack_flag_in;
   logic                    timeout_ff, timeout_in;
   logic                    done;

   logic [CMPW-1:0] cnt_max;
   logic [CMPW-1:0] pause_ext;
   logic [CMPW-1:0] pause_lim;
   logic [CMPW-1:0] stretch_lim;
   logic            is_wait;
   logic            leave;
   logic            restart;

   assign cnt_max = {{(CMPW-COUNTER_BITS){1'b0}}, {COUNTER_BITS{1'b1}}};

   always_comb begin
      pause_ext = CMPW'(pause_ticks);
      if (pause_ext == '0) begin
         pause_ext = CMPW'(1);
      end
      pause_lim   = (pause_ext > cnt_max) ? cnt_max : pause_ext;
      stretch_lim = (CMPW'(stretch_limit) > cnt_max) ? cnt_max : CMPW'(stretch_limit);
   end

   always_comb begin
      is_wait = (phase_ff == ST_W) || (phase_ff == WB_W) || (phase_ff == WA_W) ||
                (phase_ff == RB_W) || (phase_ff == RA_W) || (phase_ff == SP_W);
   end

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      pause_in     = pause_ff;
      stretch_in   = stretch_ff;
      scl_drive_in = scl_drive_ff;
      sda_drive_in = sda_drive_ff;
      ack_hold_in  = ack_hold_ff;
      recv_in      = recv_ff;
      ack_flag_in  = ack_flag_ff;
      timeout_in   = timeout_ff;
      done         = 1'b0;
      leave        = 1'b0;
      restart      = 1'b0;

      if (fire) begin
         if (phase_ff == PH_IDLE) begin
            if (req.func == FUNC_START || req.func == FUNC_WRITE ||
                req.func == FUNC_READ || req.func == FUNC_STOP) begin
               restart      = 1'b1;
               shift_in     = req.tx_byte;
               ack_hold_in  = req.ack_to_send;
               bit_count_in = '0;
               timeout_in   = 1'b0;
               case (req.func)
                  FUNC_START: begin
                     sda_drive_in = 1'b1;
                     phase_in     = ST_P1;
                  end
                  FUNC_WRITE: begin
                     sda_drive_in = req.tx_byte[7];
                     phase_in     = WB_P1;
                  end
                  FUNC_READ: begin
                     sda_drive_in = 1'b1;
                     phase_in     = RB_P0;
                  end
                  default: begin
                     sda_drive_in = 1'b0;
                     phase_in     = SP_P1;
                  end
               endcase
            end
         end else if (is_wait) begin
            if (req.scl_in) begin
               leave = 1'b1;
            end else if (CMPW'(stretch_ff) >= stretch_lim) begin
               timeout_in = 1'b1;
               leave      = 1'b1;
            end else if (stretch_ff != {COUNTER_BITS{1'b1}}) begin
               stretch_in = stretch_ff + 1'b1;
            end
         end else begin
            if (pause_ff != {COUNTER_BITS{1'b1}}) begin
               pause_in = pause_ff + 1'b1;
            end
            if (CMPW'(pause_in) >= pause_lim) begin
               leave = 1'b1;
            end
         end

         if (leave) begin
            restart = 1'b1;
            case (phase_ff)
               ST_P1: begin
                  scl_drive_in = 1'b1;
                  phase_in     = ST_W;
               end
               ST_W: phase_in = ST_P2;
               ST_P2: begin
                  sda_drive_in = 1'b0;
                  phase_in     = ST_P3;
               end
               ST_P3: begin
                  scl_drive_in = 1'b0;
                  bit_count_in = '0;
                  sda_drive_in = shift_ff[7];
                  phase_in     = WB_P1;
               end
               WB_P1: begin
                  scl_drive_in = 1'b1;
                  phase_in     = WB_P2;
               end
               WB_P2: phase_in = WB_W;
               WB_W: begin
                  scl_drive_in = 1'b0;
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_count_ff + 1'b1;
                  if (bit_count_in < 4'(BITS_PER_BYTE)) begin
                     sda_drive_in = shift_in[7];
                     phase_in     = WB_P1;
                  end else begin
                     sda_drive_in = 1'b1;
                     phase_in     = WA_P1;
                  end
               end
               WA_P1: begin
                  scl_drive_in = 1'b1;
                  phase_in     = WA_P2;
               end
               WA_P2: phase_in = WA_W;
               WA_W: begin
                  ack_flag_in  = !req.sda_in;
                  scl_drive_in = 1'b0;
                  phase_in     = PH_IDLE;
                  done         = 1'b1;
               end
               RB_P0: begin
                  scl_drive_in = 1'b1;
                  phase_in     = RB_P1;
               end
               RB_P1: phase_in = RB_W;
               RB_W: begin
                  shift_in     = {shift_ff[6:0], req.sda_in};
                  scl_drive_in = 1'b0;
                  phase_in     = RB_P2;
               end
               RB_P2: begin
                  bit_count_in = bit_count_ff + 1'b1;
                  if (bit_count_in < 4'(BITS_PER_BYTE)) begin
                     scl_drive_in = 1'b1;
                     phase_in     = RB_P1;
                  end else begin
                     sda_drive_in = !ack_hold_ff;
                     phase_in     = RA_P1;
                  end
               end
               RA_P1: begin
                  scl_drive_in = 1'b1;
                  phase_in     = RA_W;
               end
               RA_W: phase_in = RA_P2;
               RA_P2: begin
                  scl_drive_in = 1'b0;
                  phase_in     = RA_P3;
               end
               RA_P3: begin
                  sda_drive_in = 1'b1;
                  recv_in      = shift_ff;
                  phase_in     = PH_IDLE;
                  done         = 1'b1;
               end
               SP_P1: begin
                  scl_drive_in = 1'b1;
                  phase_in     = SP_P2;
               end
               SP_P2: phase_in = SP_W;
               SP_W: begin
                  sda_drive_in = 1'b1;
                  phase_in     = SP_P3;
               end
               SP_P3: begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end

         if (restart) begin
            pause_in   = '0;
            stretch_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         pause_ff     <= '0;
         stretch_ff   <= '0;
         scl_drive_ff <= 1'b1;
         sda_drive_ff <= 1'b1;
         ack_hold_ff  <= 1'b0;
         recv_ff      <= '0;
         ack_flag_ff  <= 1'b0;
         timeout_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         pause_ff     <= pause_in;
         stretch_ff   <= stretch_in;
         scl_drive_ff <= scl_drive_in;
         sda_drive_ff <= sda_drive_in;
         ack_hold_ff  <= ack_hold_in;
         recv_ff      <= recv_in;
         ack_flag_ff  <= ack_flag_in;
         timeout_ff   <= timeout_in;
      end
   end

   always_comb begin
      rsp.scl_release     = scl_drive_in;
      rsp.sda_release     = sda_drive_in;
      rsp.busy_res        = (phase_in != PH_IDLE);
      rsp.done_res        = done;
      rsp.rx_byte         = recv_in;
      rsp.ack_seen        = ack_flag_in;
      rsp.stretch_timeout = timeout_in;
   end

endmodule

`default_nettype wire
